/* sv/hbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants of the Huffman bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int SYMBOL_COUNT  = 128;
  localparam int SYM_W         = 7;
  localparam int MAX_CODE_BITS = 32;
  localparam int LEN_W         = 6;
  localparam int BYTE_W        = 8;
  localparam int BUF_W         = MAX_CODE_BITS + BYTE_W;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = 2;
  localparam int QCNT_W        = 3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  // one job handed from the front end to the back end
  typedef struct packed {
    logic                     flush;
    logic [MAX_CODE_BITS-1:0] word;
    logic [LEN_W-1:0]         len;
  } job_t;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic [2:0]        pad_count;
    logic              end_of_stream;
    logic              last;
  } result_t;

endpackage : hbp_pkg
`default_nettype wire

/* sv/hbp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_front
// Accepts input beats, keeps the code table, looks up encode symbols and
// hands encode and flush jobs to the queue.
// ----------------------------------------------------------------------------
module hbp_front
  import hbp_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  [1:0]               opcode_i,
  input  wire  [SYM_W-1:0]         symbol_i,
  input  wire  [MAX_CODE_BITS-1:0] code_word_i,
  input  wire  [LEN_W-1:0]         code_length_i,
  output logic                     push_o,
  output job_t                     job_o,
  input  wire                      full_i
);

  logic [MAX_CODE_BITS+LEN_W-1:0] mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]        ent_vld_q;
  logic [MAX_CODE_BITS+LEN_W-1:0] rd_data_q;
  logic                           rd_vld_q;
  logic                           s1_valid_q, s1_valid_d;
  logic                           s1_flush_q;
  logic                           accept;
  logic                           wr_en;
  logic                           rd_en;
  logic [LEN_W-1:0]               len_sat;
  logic [MAX_CODE_BITS-1:0]       word_masked;
  opcode_e                        op;

  assign op         = opcode_e'(opcode_i);
  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_en      = accept && (op == OP_LOAD);
  assign rd_en      = accept && ((op == OP_ENCODE) || (op == OP_FLUSH));

  assign len_sat = (code_length_i > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                          : code_length_i;
  // shifting by the full width gives zero, so a full-length code keeps all bits
  assign word_masked = code_word_i & ~({MAX_CODE_BITS{1'b1}} << len_sat);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[symbol_i] <= {word_masked, len_sat};
    end
    if (rd_en) begin
      rd_data_q <= mem[symbol_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[symbol_i] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= ent_vld_q[symbol_i];
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (push_o) begin
      s1_valid_d = 1'b0;
    end
    if (rd_en) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (rd_en) begin
        s1_flush_q <= (op == OP_FLUSH);
      end
    end
  end

  assign push_o = s1_valid_q && !full_i;

  always_comb begin
    job_o.flush = s1_flush_q;
    if (rd_vld_q) begin
      job_o.word = rd_data_q[MAX_CODE_BITS+LEN_W-1:LEN_W];
      job_o.len  = rd_data_q[LEN_W-1:0];
    end else begin
      job_o.word = '0;
      job_o.len  = '0;
    end
  end

endmodule : hbp_front
`default_nettype wire

/* sv/hbp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hbp_queue
  import hbp_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  job_t  job_i,
  output logic  full_o,
  output logic  valid_o,
  output job_t  job_o,
  input  wire   pop_i
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = slots[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_ptr_q] <= job_i;
    end
  end

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

endmodule : hbp_queue
`default_nettype wire

/* sv/hbp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_back
// Merges code bits into the bit buffer, emits one byte per cycle into the
// output register while the output is not stalled, and handles flush
// padding.
module hbp_back
  import hbp_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output result_t            res_o
);

  // bits are left aligned: the oldest bit sits in the top bit
  logic [BUF_W-1:0]         buf_q, buf_d;
  logic [LEN_W-1:0]         cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  result_t                  res_q, res_d;
  logic                     out_free;
  logic                     draining;
  logic [2:0]               pcnt;
  logic [MAX_CODE_BITS-1:0] code_la;
  logic [BUF_W-1:0]         merged;

  assign out_free = !out_valid_q || !out_stall_i;
  assign draining = (cnt_q >= LEN_W'(BYTE_W));
  assign pcnt     = cnt_q[2:0];
  assign pop_o    = q_valid_i && !draining && out_free;

  assign code_la = job_i.word << (LEN_W'(MAX_CODE_BITS) - job_i.len);
  assign merged  = {buf_q[BUF_W-1:MAX_CODE_BITS], {MAX_CODE_BITS{1'b0}}}
                 | ({code_la, {BYTE_W{1'b0}}} >> pcnt);

  always_comb begin
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    if (draining && out_free) begin
      out_valid_d         = 1'b1;
      res_d.out_byte      = buf_q[BUF_W-1:MAX_CODE_BITS];
      res_d.byte_valid    = 1'b1;
      res_d.pad_count     = '0;
      res_d.end_of_stream = 1'b0;
      res_d.last          = (cnt_q < LEN_W'(2*BYTE_W));
      buf_d               = buf_q << BYTE_W;
      cnt_d               = cnt_q - LEN_W'(BYTE_W);
    end else if (pop_o) begin
      if (job_i.flush) begin
        out_valid_d         = 1'b1;
        res_d.out_byte      = buf_q[BUF_W-1:MAX_CODE_BITS];
        res_d.byte_valid    = (pcnt != '0);
        res_d.pad_count     = 3'(4'd8 - {1'b0, pcnt});
        res_d.end_of_stream = 1'b1;
        res_d.last          = 1'b1;
        buf_d               = '0;
        cnt_d               = '0;
      end else begin
        buf_d = merged;
        cnt_d = {{(LEN_W-3){1'b0}}, pcnt} + job_i.len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule : hbp_back
`default_nettype wire

/* sv/huffman_bit_packer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: an encode beat passes the table read register, the queue and the bit
//   buffer before its first byte enters the output register; a flush beat
//   passes the table read register and the queue before its result enters it.
// Throughput: one beat per cycle at the input while in_stall_o is low; the back
//   end takes no new encode or flush job until it has emitted every whole byte (up to 4 per encode).
// Reset: asynchronous, active low; all code lengths read as zero, no pending bits.
// ----------------------------------------------------------------------------
// huffman_bit_packer
// Huffman encoder back end: code table, bit packing into MSB-first bytes,
// flush with zero padding.
// ----------------------------------------------------------------------------
module huffman_bit_packer
  import hbp_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  [1:0]               opcode_i,
  input  wire  [SYM_W-1:0]         symbol_i,
  input  wire  [MAX_CODE_BITS-1:0] code_word_i,
  input  wire  [LEN_W-1:0]         code_length_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic [BYTE_W-1:0]        out_byte_o,
  output logic                     byte_valid_o,
  output logic [2:0]               pad_count_o,
  output logic                     end_of_stream_o,
  output logic                     last_o
);

  logic    push;
  logic    full;
  logic    q_valid;
  logic    pop;
  job_t    push_job;
  job_t    head_job;
  result_t res;

  hbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .symbol_i      (symbol_i),
    .code_word_i   (code_word_i),
    .code_length_i (code_length_i),
    .push_o        (push),
    .job_o         (push_job),
    .full_i        (full)
  );

  hbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  hbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_byte_o      = res.out_byte;
  assign byte_valid_o    = res.byte_valid;
  assign pad_count_o     = res.pad_count;
  assign end_of_stream_o = res.end_of_stream;
  assign last_o          = res.last;

endmodule : huffman_bit_packer
`default_nettype wire

/* sv/hbp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks of the Huffman bit packer output beats.
// ----------------------------------------------------------------------------
module hbp_checker
  import hbp_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input wire [BYTE_W-1:0]   out_byte_o,
  input wire                byte_valid_o,
  input wire [2:0]          pad_count_o,
  input wire                end_of_stream_o,
  input wire                last_o
);

  // a stalled beat holds its byte
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output beat changed while stalled");

  // a flush beat always closes its item
  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_stream_o |-> last_o)
    else $error("flush beat without last");

  // padding only on a flush that carried bits
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pad_count_o != 3'd0 |-> end_of_stream_o && byte_valid_o)
    else $error("pad count outside a flush byte");

  // only an empty flush gives a beat without data
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> end_of_stream_o && out_byte_o == 8'd0)
    else $error("empty beat that is not an empty flush");

endmodule : hbp_checker

bind huffman_bit_packer hbp_checker u_hbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .byte_valid_o    (byte_valid_o),
  .pad_count_o     (pad_count_o),
  .end_of_stream_o (end_of_stream_o),
  .last_o          (last_o)
);
`default_nettype wire
